[src/nvp_pkg.sv]
// Shared constants for the variable-width bit packer.
`default_nettype none

package nvp_pkg;

  // Width of the incoming value field.
  localparam int unsigned VALUE_BITS = 31;

  // Width of the bits-per-value register and its value after reset.
  localparam int unsigned CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  // Smallest legal width; a programmed zero is raised to this.
  localparam logic [CFG_BITS-1:0] MIN_WIDTH = 5'd1;

  // Depth of the result queue and its pointer and count widths.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS = 2;
  localparam int unsigned QCNT_BITS = 3;

  // Input is taken while at most this many results wait, so a flush that
  // yields two words always finds room.
  localparam logic [QCNT_BITS-1:0] QUEUE_ROOM = 3'd2;

  // Pad of the value field to whole bytes on the input data bus.
  localparam int unsigned IN_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

[src/nbit_value_packer.sv]
// Variable-width MSB-first bit packer: values in, packed words out.
//
// Usage:
//   Program the value width (1 to 31, zero counts as 1) on the cfg channel
//   while the block is idle; after reset the width is 16. Values enter on the
//   s_axis channel (value in tdata, end of array on tlast). Packed words leave
//   on the m_axis channel, the first value in the most significant bits; the
//   final word of an array, zero-padded below its data, carries tlast.
// Flow: an accepted beat waits in the input register until the queue has
//   room, then is packed; any word it completes joins the result queue for m_axis.
// Throughput: one value per cycle while the queue has room. The result queue
//   takes one word out per cycle, so a flush that completes a full word and
//   leaves a partial word (two results for one value) queues both at once.
// Reset: the width returns to 16, the held bits and the queue are emptied.
// Stalls: while m_axis_tready is low the four-entry result queue fills; the
//   input stalls once more than two words wait, and no word is ever dropped.
`default_nettype none

module nbit_value_packer #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write channel: bits per value.
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [nvp_pkg::CFG_BITS-1:0]         cfg_data_i,
  // Input stream.
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // Bits from lowest: value [30:0], zero pad [31].
  input  wire logic [nvp_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
  input  wire logic                                 s_axis_tlast,
  // Output stream.
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // Bits from lowest: packed_word [WORD_BITS-1:0], then zero pad to bytes.
  output logic [((WORD_BITS + 7) / 8) * 8 - 1:0]    m_axis_tdata,
  output logic                                      m_axis_tlast
);

  localparam int unsigned OUT_TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;
  localparam int unsigned HW = $clog2(WORD_BITS);
  localparam int unsigned SW = HW + 1;
  localparam int unsigned VB = nvp_pkg::VALUE_BITS;
  localparam int unsigned CB = nvp_pkg::CFG_BITS;
  localparam int unsigned QD = nvp_pkg::QUEUE_DEPTH;
  localparam int unsigned PB = nvp_pkg::QPTR_BITS;
  localparam int unsigned NB = nvp_pkg::QCNT_BITS;

  // Configuration register.
  logic [CB-1:0] bpv_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpv_q <= nvp_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      bpv_q <= cfg_data_i;
    end
  end

  // Input register.
  logic          stage_v_q;
  logic [VB-1:0] stage_value_q;
  logic          stage_last_q;
  logic          advance;
  logic [NB-1:0] cnt_q;

  assign advance       = stage_v_q && (cnt_q <= nvp_pkg::QUEUE_ROOM);
  assign s_axis_tready = !stage_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      stage_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage_value_q <= s_axis_tdata[VB-1:0];
      stage_last_q  <= s_axis_tlast;
    end
  end

  // Packing logic: merge the staged value into the held bits.
  logic [WORD_BITS-1:0] acc_q, acc_d, acc_new, v_word, full_word;
  logic [HW-1:0]        held_q, held_d, held_new;
  logic [CB-1:0]        width;
  logic [VB-1:0]        v_masked;
  logic [SW-1:0]        space, over, lo_shift, hi_shift;
  logic                 fits;
  logic [1:0]           push_n;
  logic [WORD_BITS-1:0] r0_word, r1_word;
  logic                 r0_last;

  always_comb begin
    width    = (bpv_q == '0) ? nvp_pkg::MIN_WIDTH : bpv_q;
    v_masked = stage_value_q & ({VB{1'b1}} >> (CB'(VB) - width));
    v_word   = WORD_BITS'(v_masked);
    space    = SW'(WORD_BITS) - SW'(held_q);
    fits     = SW'(width) < space;
    lo_shift = space - SW'(width);
    over     = SW'(width) - space;
    hi_shift = SW'(WORD_BITS) - over;
    full_word = acc_q | (v_word >> over);

    if (fits) begin
      acc_new  = acc_q | (v_word << lo_shift);
      held_new = held_q + HW'(width);
    end else begin
      acc_new  = (over == '0) ? '0 : (v_word << hi_shift);
      held_new = HW'(over);
    end

    // Results for this value: a completed word and/or the flushed partial word.
    push_n  = 2'd0;
    r0_word = full_word;
    r0_last = 1'b0;
    r1_word = acc_new;
    if (!fits) begin
      push_n  = 2'd1;
      r0_last = stage_last_q && (held_new == '0);
      if (stage_last_q && (held_new != '0)) begin
        push_n = 2'd2;
      end
    end else if (stage_last_q) begin
      push_n  = 2'd1;
      r0_word = acc_new;
      r0_last = 1'b1;
    end

    acc_d  = acc_q;
    held_d = held_q;
    if (advance) begin
      acc_d  = stage_last_q ? '0 : acc_new;
      held_d = stage_last_q ? '0 : held_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
    end else begin
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

  // Result queue: up to two words written per cycle, one read.
  logic [WORD_BITS-1:0] q_word_q [QD];
  logic                 q_last_q [QD];
  logic [PB-1:0]        wr_q, rd_q, wr_d, rd_d, wr_next;
  logic [NB-1:0]        cnt_d;
  logic                 pop;
  logic [1:0]           push_cnt;

  assign push_cnt      = advance ? push_n : 2'd0;
  assign m_axis_tvalid = (cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign wr_next       = wr_q + PB'(1);
  assign wr_d          = wr_q + PB'(push_cnt);
  assign rd_d          = rd_q + PB'(pop);
  assign cnt_d         = cnt_q + NB'(push_cnt) - NB'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      q_word_q[wr_q] <= r0_word;
      q_last_q[wr_q] <= r0_last;
    end
    if (push_cnt == 2'd2) begin
      q_word_q[wr_next] <= r1_word;
      q_last_q[wr_next] <= 1'b1;
    end
  end

  assign m_axis_tdata = OUT_TDATA_BITS'(q_word_q[rd_q]);
  assign m_axis_tlast = q_last_q[rd_q];

`ifndef NO_ASSERTIONS
  // The queue never holds more words than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= NB'(QD))
    else $error("result queue overflow");

  // Fewer than a full word of bits is ever held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) < WORD_BITS)
    else $error("held bit count out of range");

  // A packed end-of-array value leaves the accumulator empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_last_q) |=> (held_q == '0 && acc_q == '0))
    else $error("flush did not clear held bits");

  // Input only stalls behind a staged value waiting for queue room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (stage_v_q && cnt_q > nvp_pkg::QUEUE_ROOM))
    else $error("input stalled without cause");

  // Two results per value only happen at the end of an array.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt == 2'd2) |-> stage_last_q)
    else $error("double result without flush");
`endif

endmodule

`default_nettype wire
